// ===== rtl/sfrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver package
// Shared constants, codes and the item record passed from the parser to the
// dispatch stage.
// ----------------------------------------------------------------------------
package sfrd_pkg;

   localparam int unsigned FRAME_DEPTH_DEF = 255;
   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   localparam logic [7:0] START_BYTE      = 8'hAA;
   localparam logic [7:0] STOP_BYTE       = 8'h55;
   localparam logic [7:0] LONG_MARK       = 8'hFF;
   localparam logic [7:0] CMD_MOTOR       = 8'h01;
   localparam logic [7:0] CMD_RELAY_ONE   = 8'h03;
   localparam logic [7:0] CMD_RELAY_TWO   = 8'h11;
   localparam logic [7:0] CMD_RELAY_THREE = 8'h12;
   localparam logic [7:0] CMD_BLINK       = 8'h10;
   localparam logic [7:0] CMD_DIMMER      = 8'h09;
   localparam logic [6:0] DUTY_MAX        = 7'd100;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PAYLOAD = 2'd1,
      EV_ACCEPT  = 2'd2,
      EV_DROP    = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_BUZZER = 2'd1,
      ACT_MOTOR  = 2'd2,
      ACT_BLINK  = 2'd3
   } action_type;

   typedef struct packed {
      event_type  ev;
      logic [7:0]  data;
      logic [7:0]  addr;
      logic [7:0]  cmd;
      logic [15:0] plen;
      logic        lf;
      logic [6:0]  duty;
      action_type  act;
   } item_type;

endpackage

// ===== rtl/sfrd_front.sv =====
// ----------------------------------------------------------------------------
// Frame parser
// Tracks the position within a frame, captures the length and header bytes
// and classifies every received byte into an item for the dispatch stage.
// ----------------------------------------------------------------------------
module sfrd_front #(
   parameter int unsigned FRAME_DEPTH = sfrd_pkg::FRAME_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_wdata,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   output logic               push_valid,
   input  logic               push_ready,
   output sfrd_pkg::item_type push_item
);

   localparam int unsigned POS_W = $clog2(FRAME_DEPTH);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       short_ff, short_in;
   logic [15:0]      wide_ff, wide_in;
   logic [7:0]       addr_ff, addr_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [7:0]       first_ff, first_in;
   logic             enable_ff;

   logic             accept;
   logic             longf;
   logic [16:0]      pos_w, stop, off, nxt;
   sfrd_pkg::item_type item;

   assign csr_ready  = 1'b1;
   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign push_item  = item;
   assign accept     = req_tvalid & push_ready;

   always_comb begin
      short_in = short_ff;
      wide_in  = wide_ff;
      addr_in  = addr_ff;
      cmd_in   = cmd_ff;
      first_in = first_ff;
      pos_in   = pos_ff;
      pos_w    = 17'(pos_ff);
      nxt      = pos_w + 17'd1;
      item     = '0;
      item.ev  = sfrd_pkg::EV_NONE;
      item.act = sfrd_pkg::ACT_NONE;
      item.data = req_tdata;
      item.duty = (first_ff >= 8'(sfrd_pkg::DUTY_MAX)) ? sfrd_pkg::DUTY_MAX : first_ff[6:0];

      if (pos_w == 17'd1) begin
         short_in = req_tdata;
      end
      longf = (short_in == sfrd_pkg::LONG_MARK);
      if (longf && pos_w == 17'd2) begin
         wide_in[7:0] = req_tdata;
      end
      if (longf && pos_w == 17'd3) begin
         wide_in[15:8] = req_tdata;
      end
      off  = longf ? 17'd4 : 17'd2;
      stop = longf ? (17'(wide_in) + 17'd4) : (17'(short_in) + 17'd2);

      if (pos_w == 17'd0) begin
         if (req_tdata == sfrd_pkg::START_BYTE) begin
            addr_in  = '0;
            cmd_in   = '0;
            first_in = '0;
            pos_in   = POS_W'(1);
         end
      end else if (pos_w == stop) begin
         pos_in = '0;
         if (req_tdata == sfrd_pkg::STOP_BYTE && enable_ff) begin
            item.ev   = sfrd_pkg::EV_ACCEPT;
            item.addr = addr_ff;
            item.cmd  = cmd_ff;
            unique case (cmd_ff)
               sfrd_pkg::CMD_MOTOR: item.act = sfrd_pkg::ACT_MOTOR;
               sfrd_pkg::CMD_BLINK: item.act = sfrd_pkg::ACT_BLINK;
               default:             item.act = sfrd_pkg::ACT_BUZZER;
            endcase
         end else begin
            item.ev = sfrd_pkg::EV_DROP;
         end
      end else begin
         if (pos_w >= off) begin
            item.ev = sfrd_pkg::EV_PAYLOAD;
            if (pos_w == off) begin
               addr_in = req_tdata;
            end else if (pos_w == off + 17'd1) begin
               cmd_in = req_tdata;
            end else if (pos_w == off + 17'd2) begin
               first_in = req_tdata;
            end
         end
         if (nxt >= 17'(FRAME_DEPTH)) begin
            pos_in  = '0;
            item.ev = sfrd_pkg::EV_DROP;
         end else begin
            pos_in = nxt[POS_W-1:0];
         end
      end

      if (item.ev != sfrd_pkg::EV_NONE) begin
         item.plen = longf ? wide_in : 16'(short_in);
         item.lf   = longf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         short_ff  <= '0;
         wide_ff   <= '0;
         addr_ff   <= '0;
         cmd_ff    <= '0;
         first_ff  <= '0;
         enable_ff <= 1'b0;
      end else begin
         if (accept) begin
            pos_ff   <= pos_in;
            short_ff <= short_in;
            wide_ff  <= wide_in;
            addr_ff  <= addr_in;
            cmd_ff   <= cmd_in;
            first_ff <= first_in;
         end
         if (csr_valid) begin
            enable_ff <= csr_wdata;
         end
      end
   end

endmodule

// ===== rtl/sfrd_queue.sv =====
// ----------------------------------------------------------------------------
// Item queue
// Short first-in first-out buffer that decouples the parser from the
// dispatch stage.
// ----------------------------------------------------------------------------
module sfrd_queue #(
   parameter int unsigned DEPTH = sfrd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  sfrd_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output sfrd_pkg::item_type pop_item
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   sfrd_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/sfrd_back.sv =====
// ----------------------------------------------------------------------------
// Command dispatch stage
// Carries out accepted commands on the relay and dimmer state and holds the
// result item in an output register until it is taken.
// ----------------------------------------------------------------------------
module sfrd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  sfrd_pkg::item_type pop_item,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output sfrd_pkg::item_type rsp_item,
   output logic [2:0]         rsp_relays,
   output logic [6:0]         rsp_duty
);

   logic               valid_ff;
   sfrd_pkg::item_type item_ff;
   logic [2:0]         relay_ff, relay_in;
   logic [6:0]         duty_ff, duty_in;
   logic               pop_fire;

   assign pop_ready  = !valid_ff || rsp_tready;
   assign pop_fire   = pop_valid & pop_ready;
   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;
   assign rsp_relays = relay_ff;
   assign rsp_duty   = duty_ff;

   always_comb begin
      relay_in = relay_ff;
      duty_in  = duty_ff;
      if (pop_item.ev == sfrd_pkg::EV_ACCEPT) begin
         unique case (pop_item.cmd)
            sfrd_pkg::CMD_RELAY_ONE:   relay_in = relay_ff ^ 3'b001;
            sfrd_pkg::CMD_RELAY_TWO:   relay_in = relay_ff ^ 3'b010;
            sfrd_pkg::CMD_RELAY_THREE: relay_in = relay_ff ^ 3'b100;
            sfrd_pkg::CMD_DIMMER:      duty_in  = pop_item.duty;
            default:                   relay_in = relay_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         relay_ff <= '0;
         duty_ff  <= '0;
      end else begin
         if (pop_fire) begin
            valid_ff <= 1'b1;
            relay_ff <= relay_in;
            duty_ff  <= duty_in;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_fire) begin
         item_ff <= pop_item;
      end
   end

`ifndef ASSERT_OFF
   duty_in_range: assert property (@(posedge clock) disable iff (reset)
      duty_ff <= sfrd_pkg::DUTY_MAX)
      else $error("Dimmer duty is above its maximum.");

   relay_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && relay_ff != $past(relay_ff)) |->
         $past(pop_fire && pop_item.ev == sfrd_pkg::EV_ACCEPT))
      else $error("Relay levels changed without an accepted frame.");

   pulse_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && item_ff.act != sfrd_pkg::ACT_NONE) |->
         item_ff.ev == sfrd_pkg::EV_ACCEPT)
      else $error("Action pulse reported without an accepted frame.");
`endif

endmodule

// ===== rtl/serial_frame_receiver_dispatch_unit.sv =====
// A result item passes through an item queue entry and then the output register before it is offered.
// One byte per cycle while the item queue has room; each byte gives exactly one result item.
// The parser, the item queue and the output register each take one item per cycle;
// while a result is stalled the queue still takes up to QUEUE_DEPTH more bytes.
// Reset clears the frame position, held bytes, relays, duty and dispatch enable.
// ----------------------------------------------------------------------------
// Serial frame receiver with command dispatch
// Parses start, length, payload and stop bytes and drives relays, the dimmer
// duty and action pulses from accepted frames.
// ----------------------------------------------------------------------------
module serial_frame_receiver_dispatch_unit #(
   parameter int unsigned FRAME_DEPTH = sfrd_pkg::FRAME_DEPTH_DEF,
   parameter int unsigned QUEUE_DEPTH = sfrd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_wdata,   // dispatch_enable
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // event_res
   // data_byte, frame_addr, frame_command, declared_length, long_form, relay_one,
   // relay_two, relay_three, dimmer_duty, action_pulse, zero fill
   output logic [55:0] rsp_tdata
);

   logic               push_valid, push_ready;
   sfrd_pkg::item_type push_item;
   logic               pop_valid, pop_ready;
   sfrd_pkg::item_type pop_item;
   sfrd_pkg::item_type rsp_item;
   logic [2:0]         rsp_relays;
   logic [6:0]         rsp_duty;

   sfrd_front #(
      .FRAME_DEPTH(FRAME_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   sfrd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   sfrd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item),
      .rsp_relays (rsp_relays),
      .rsp_duty   (rsp_duty)
   );

   assign rsp_tuser = rsp_item.ev;
   assign rsp_tdata = {3'b000, rsp_item.act, rsp_duty, rsp_relays[2], rsp_relays[1],
                       rsp_relays[0], rsp_item.lf, rsp_item.plen, rsp_item.cmd,
                       rsp_item.addr, rsp_item.data};

endmodule
